FILE: rtl/core/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;
    typedef enum logic [3:0] {
        ST_BCLR,
        ST_BSCAN,
        ST_BREAD,
        ST_BMARK,
        ST_IDLE,
        ST_CLR,
        ST_PFETCH,
        ST_PREAD,
        ST_PSQ,
        ST_DIV,
        ST_MARK,
        ST_EMIT,
        ST_LAST
    } state_t;

    localparam int unsigned MAX_RESULTS = 32;
    localparam logic [32:0] TOP_VALUE = 33'h0_FFFF_FFFF;
endpackage

FILE: rtl/core/segmented_prime_sieve.sv
`timescale 1ns / 1ps
// Segmented prime sieve.
// After reset the block sieves all numbers below BASE_LIMIT and stores the
// base primes, up to BASE_TABLE_DEPTH of them, in a table. busy stays high
// during this build, which clears every flag, then scans each number, stores
// each prime found and marks its multiples from its square upward.
// A request is taken when start is high and busy is low: window_low and
// window_span name the window [low, low+span], end capped at 2^32-1.
// busy rises the next cycle. The window marks are cleared first. For each
// base prime p with p*p <= window end, a shared 33-bit restoring divider
// finds ceil(low/p); after fetch, square test and first-multiple setup, the
// multiples of p are marked one at a time by the shared adder. The window is
// then scanned one offset per cycle. Each prime is held one step so the final
// one can carry is_last; results are strobed on valid for a single cycle with
// prime_value and found=1. A window with no prime gives one strobe with
// found=0, is_last=1. A request takes longest when the window end is near
// 2^32 and every base prime is used; busy falls the cycle after the last
// strobe. The receiver cannot stall; results are not held.
// Reset clears state_reg, i_reg, cnt_reg, n_reg and restarts the base build.
module segmented_prime_sieve
    import sps_pkg::*;
#(
    parameter int unsigned BASE_LIMIT       = 65536,
    parameter int unsigned BASE_TABLE_DEPTH = 8192,
    parameter int unsigned WINDOW_SIZE      = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] window_low,
    input  logic [5:0]  window_span,
    output logic        valid,
    output logic [31:0] prime_value,
    output logic        found,
    output logic        is_last
);
    localparam int BW = $clog2(BASE_LIMIT);
    localparam int TW = $clog2(BASE_TABLE_DEPTH);
    localparam int WW = $clog2(WINDOW_SIZE);
    localparam int CW = TW + 1;
    localparam int RW = $clog2(MAX_RESULTS + 1);

    // Base flags: 1 means composite (inverted sense so clear pass writes 0).
    logic              bflag_mem [BASE_LIMIT];
    logic [15:0]       ptab_mem  [BASE_TABLE_DEPTH];
    logic              wmark_mem [WINDOW_SIZE];

    state_t            state_reg, state_next;
    logic [BW:0]       i_reg, i_next;       // base index / loop counter
    logic [BW+BW:0]    j_reg, j_next;       // base marking index
    logic [CW-1:0]     cnt_reg, cnt_next;   // base prime count
    logic [CW-1:0]     k_reg, k_next;
    logic [32:0]       lo_reg, lo_next, hi_reg, hi_next;
    logic [16:0]       p_reg, p_next;
    logic [33:0]       v_reg, v_next;       // multiple walker / scan value
    logic [32:0]       q_reg, q_next, rem_reg, rem_next;
    logic [5:0]        dc_reg, dc_next;
    logic [RW-1:0]     n_reg, n_next;       // primes found so far
    logic [31:0]       pend_reg, pend_next; // latest prime, held one step
    logic              bflag_rd_reg, wmark_rd_reg;
    logic [15:0]       ptab_rd_reg;

    // Memory control
    logic              bf_we, bf_wd;
    logic [BW-1:0]     bf_wa, bf_ra;
    logic              pt_we;
    logic [TW-1:0]     pt_a;
    logic              wm_we, wm_wd;
    logic [WW-1:0]     wm_wa, wm_ra;

    logic [5:0]        span_c;
    logic [33:0]       hi_raw, sq, rtrial;
    logic [32:0]       rshift;

    always_ff @(posedge clk)
    begin
        if (bf_we) bflag_mem[bf_wa] <= bf_wd;
        bflag_rd_reg <= bflag_mem[bf_ra];
        if (pt_we) ptab_mem[pt_a] <= i_reg[15:0];
        ptab_rd_reg <= ptab_mem[pt_a];
        if (wm_we) wmark_mem[wm_wa] <= wm_wd;
        wmark_rd_reg <= wmark_mem[wm_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BCLR;
            i_reg     <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        k_reg    <= k_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        p_reg    <= p_next;
        v_reg    <= v_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dc_reg   <= dc_next;
        pend_reg <= pend_next;
    end

    assign span_c = (32'(window_span) > WINDOW_SIZE - 1) ? 6'(WINDOW_SIZE - 1) : window_span;
    assign hi_raw = {2'b0, window_low} + 34'(span_c);
    assign sq     = 34'(p_reg) * 34'(p_reg);
    assign rshift = {rem_reg[31:0], q_reg[32]};
    assign rtrial = {1'b0, rshift} - 34'(p_reg);

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; cnt_next = cnt_reg; k_next = k_reg;
        lo_next = lo_reg; hi_next = hi_reg; p_next = p_reg; v_next = v_reg;
        q_next = q_reg; rem_next = rem_reg; dc_next = dc_reg; n_next = n_reg;
        pend_next = pend_reg;
        bf_we = 1'b0; bf_wd = 1'b0; bf_wa = i_reg[BW-1:0]; bf_ra = i_reg[BW-1:0];
        pt_we = 1'b0; pt_a = k_reg[TW-1:0];
        wm_we = 1'b0; wm_wd = 1'b0; wm_wa = i_reg[WW-1:0]; wm_ra = i_reg[WW-1:0];
        busy = 1'b1; valid = 1'b0; prime_value = '0; found = 1'b0; is_last = 1'b0;
        unique case (state_reg)
            ST_BCLR:
            begin
                // clear all composite flags, one per cycle
                bf_we = 1'b1;
                if (i_reg == (BW+1)'(BASE_LIMIT - 1))
                begin
                    i_next = (BW+1)'(2);
                    state_next = ST_BSCAN;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            ST_BSCAN:
            begin
                if (i_reg >= (BW+1)'(BASE_LIMIT))
                    state_next = ST_IDLE;
                else
                    state_next = ST_BREAD;
            end
            ST_BREAD:
            begin
                if (bflag_rd_reg)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_BSCAN;
                end
                else
                begin
                    if (cnt_reg < CW'(BASE_TABLE_DEPTH))
                    begin
                        pt_we = 1'b1;
                        pt_a = cnt_reg[TW-1:0];
                        cnt_next = cnt_reg + 1'b1;
                    end
                    j_next = (2*BW+1)'(i_reg) * (2*BW+1)'(i_reg);
                    state_next = ST_BMARK;
                end
            end
            ST_BMARK:
            begin
                if (j_reg >= (2*BW+1)'(BASE_LIMIT))
                begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_BSCAN;
                end
                else
                begin
                    bf_we = 1'b1; bf_wd = 1'b1; bf_wa = j_reg[BW-1:0];
                    j_next = j_reg + (2*BW+1)'(i_reg);
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                i_next = '0;
                if (start)
                begin
                    lo_next = {1'b0, window_low};
                    hi_next = (hi_raw > 34'(TOP_VALUE)) ? TOP_VALUE : hi_raw[32:0];
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                wm_we = 1'b1;
                if (i_reg == (BW+1)'(WINDOW_SIZE - 1))
                begin
                    k_next = '0;
                    state_next = ST_PFETCH;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            ST_PFETCH:
            begin
                if (k_reg >= cnt_reg)
                begin
                    v_next = {1'b0, lo_reg}; n_next = '0; i_next = '0;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_PREAD;
            end
            ST_PREAD:
            begin
                p_next = {1'b0, ptab_rd_reg};
                state_next = ST_PSQ;
            end
            ST_PSQ:
            begin
                if (p_reg < 17'd2)
                begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_PFETCH;
                end
                else if (sq > 34'(hi_reg))
                begin
                    v_next = {1'b0, lo_reg}; n_next = '0; i_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    // dividend lo+p-1, one quotient bit per cycle
                    q_next = lo_reg + 33'(p_reg) - 33'd1;
                    rem_next = '0;
                    dc_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                q_next = {q_reg[31:0], ~rtrial[33]};
                rem_next = rtrial[33] ? rshift : rtrial[32:0];
                dc_next = dc_reg + 1'b1;
                if (dc_reg == 6'd32)
                begin
                    // reuse v as multiply result input: q * p
                    state_next = ST_MARK;
                    v_next = '1;
                end
            end
            ST_MARK:
            begin
                if (v_reg == '1)
                begin
                    // first multiple: max(ceil*p, p*p)
                    v_next = (34'(q_reg[32:0]) * 34'(p_reg) < sq)
                             ? sq : 34'(q_reg[32:0]) * 34'(p_reg);
                end
                else if (v_reg > 34'(hi_reg))
                begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_PFETCH;
                end
                else
                begin
                    wm_we = 1'b1; wm_wd = 1'b1;
                    wm_wa = WW'(v_reg - 34'(lo_reg));
                    v_next = v_reg + 34'(p_reg);
                end
            end
            ST_EMIT:
            begin
                // i_reg nonzero once the first mark read is back; v_reg is the
                // number whose mark sits in wmark_rd_reg
                if (i_reg != '0)
                begin
                    if (!wmark_rd_reg && v_reg >= 34'd2)
                    begin
                        // release the held prime, hold this one until the next
                        if (n_reg != '0)
                        begin
                            valid = 1'b1; found = 1'b1; prime_value = pend_reg;
                        end
                        pend_next = v_reg[31:0];
                        n_next = n_reg + 1'b1;
                        if (n_reg == RW'(MAX_RESULTS - 1))
                            state_next = ST_LAST;
                    end
                    if (v_reg == 34'(hi_reg))
                        state_next = ST_LAST;
                    if (state_next == ST_EMIT)
                        v_next = v_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                wm_ra = WW'(v_next - 34'(lo_reg));
                if (i_reg == '0) wm_ra = '0;
            end
            ST_LAST:
            begin
                // drain the held prime with is_last, or report an empty window
                valid = 1'b1; is_last = 1'b1;
                if (n_reg != '0)
                begin
                    found = 1'b1; prime_value = pend_reg;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy);
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !valid);
    a_found_value: assert property (@(posedge clk) disable iff (!rst_n)
        valid && found |-> prime_value >= 32'd2);
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !found |-> is_last && prime_value == 32'd0);
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_last |=> !busy);
endmodule
